### src/scml_pkg.sv
// shared types and constants for the stepped colour map lookup
package scml_pkg;

	localparam int MaxPoints = 16;
	localparam int MaxSteps = 1024;
	localparam int ChannelBits = 8;
	localparam int IdxBits = $clog2(MaxPoints);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_VALUE = 2'd1,
		OP_STEP = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_MIN = 2'd0,
		REG_MAX = 2'd1,
		REG_STEPS = 2'd2,
		REG_POINTS = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] entry_index;
		logic [16:0] entry_position;
		logic [7:0] entry_red;
		logic [7:0] entry_green;
		logic [7:0] entry_blue;
		logic [7:0] entry_alpha;
		logic signed [31:0] sample_value;
		logic [9:0] step_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0] color_red;
		logic [7:0] color_green;
		logic [7:0] color_blue;
		logic [7:0] color_alpha;
		logic status;
	} result_t;

endpackage

### src/stepped_color_map_lookup.sv
// stepped colour map lookup: entry table in memory, shared serial divider
// One command is taken at a time. An entry write never raises busy. The lookups share
// one restoring divider that retires one quotient bit per cycle: 49 bits for the value
// normalisation, 33 for the quantised position of a value lookup, 26 for the position
// of a step lookup and 27 for each of the four channels, run one after another. The
// segment search makes one memory read per visited upper entry and one for the lower
// entry, each passing through ST_RD and ST_CMP. A flat or descending segment skips
// the channel divisions. A step lookup returns the entry colour directly when the
// step count equals the point count; a bad step index sets status with colour zero.
// The result appears for exactly one cycle with done high, in the cycle after the last
// busy cycle, and cannot be stalled. Busy is already low while done is high, so the next
// command can be taken at the edge that ends the result transfer. Configuration writes
// are always ready and must only be made while busy is low.
module stepped_color_map_lookup (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  scml_pkg::cmd_t cmd,
	output logic done,
	output scml_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_NORM = 11'b00000000010,
		ST_QUANT = 11'b00000000100,
		ST_SPOS = 11'b00000001000,
		ST_RD = 11'b00000010000,
		ST_CMP = 11'b00000100000,
		ST_SEG = 11'b00001000000,
		ST_CH = 11'b00010000000,
		ST_DIRECT = 11'b00100000000,
		ST_DIRW = 11'b01000000000,
		ST_OUT = 11'b10000000000
	} state_t;

	localparam int DW = 49;

	// configuration
	logic signed [31:0] min_q, max_q;
	logic [10:0] steps_cfg_q;
	logic [4:0] points_cfg_q;

	// entry memories
	logic [16:0] pos_mem [scml_pkg::MaxPoints];
	logic [31:0] col_mem [scml_pkg::MaxPoints];
	logic [3:0] rd_addr;
	logic [16:0] rd_pos_q;
	logic [31:0] rd_col_q;

	state_t state_q;
	logic [3:0] seg_q;
	logic [1:0] ch_q;
	logic phase_q; // segment read: 0 reads upper entry, 1 reads lower entry
	logic [16:0] q_q, p0_q, p1_q;
	logic [31:0] c0_q, c1_q;
	logic [31:0] col_acc_q;
	logic status_q;
	logic [10:0] steps;
	logic [4:0] points;

	// shared restoring divider
	logic [DW-1:0] num_q, quo_q;
	logic [DW-1:0] rem_q;
	logic [33:0] den_q;
	logic [5:0] cnt_q;
	logic div_run;
	logic [DW:0] rem_shift;
	logic rem_ge;

	assign steps = (steps_cfg_q < 11'd2) ? 11'd2 :
		(steps_cfg_q > 11'(scml_pkg::MaxSteps)) ? 11'(scml_pkg::MaxSteps) : steps_cfg_q;
	assign points = (points_cfg_q < 5'd2) ? 5'd2 :
		(points_cfg_q > 5'(scml_pkg::MaxPoints)) ? 5'(scml_pkg::MaxPoints) : points_cfg_q;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign div_run = (cnt_q != 6'd0);
	assign rem_shift = {rem_q, num_q[DW-1]};
	assign rem_ge = (rem_shift >= {{(DW-33){1'b0}}, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 32'sd0;
			max_q <= 32'sd65536;
			steps_cfg_q <= 11'd16;
			points_cfg_q <= 5'd2;
		end else if (cfg_valid) begin
			unique case (scml_pkg::reg_index_t'(cfg_index))
				scml_pkg::REG_MIN: min_q <= cfg_data;
				scml_pkg::REG_MAX: max_q <= cfg_data;
				scml_pkg::REG_STEPS: steps_cfg_q <= cfg_data[10:0];
				scml_pkg::REG_POINTS: points_cfg_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (start && !busy && scml_pkg::opcode_t'(cmd.opcode) == scml_pkg::OP_WRITE) begin
			pos_mem[cmd.entry_index] <= (cmd.entry_position > 17'd65536) ? 17'd65536
				: cmd.entry_position;
			col_mem[cmd.entry_index] <= {cmd.entry_alpha, cmd.entry_blue,
				cmd.entry_green, cmd.entry_red};
		end
		rd_pos_q <= pos_mem[rd_addr];
		rd_col_q <= col_mem[rd_addr];
	end

	// derived values for launching divisions
	logic signed [32:0] v_clamp, range_w, off_w;
	logic [32:0] range_u, off_u;
	logic [16:0] den_seg, t_raw, t_cl;
	logic [7:0] cha, chb;
	logic [26:0] mix;
	logic [26:0] p_times;

	always_comb begin
		v_clamp = 33'(cmd.sample_value);
		if (cmd.sample_value < min_q) v_clamp = 33'(min_q);
		if (cmd.sample_value > max_q) v_clamp = 33'(max_q);
		range_w = 33'(max_q) - 33'(min_q);
		off_w = v_clamp - 33'(min_q);
		range_u = range_w;
		off_u = off_w;
		den_seg = p1_q - p0_q;
		t_raw = (q_q > p0_q) ? (q_q - p0_q) : 17'd0;
		t_cl = (t_raw > den_seg) ? den_seg : t_raw;
		cha = c0_q[ch_q*8 +: 8];
		chb = c1_q[ch_q*8 +: 8];
		mix = 27'(cha) * 27'(den_seg - t_cl) + 27'(chb) * 27'(t_cl) + 27'(den_seg >> 1);
		p_times = 27'(quo_q[16:0]) * 27'(steps - 11'd1);
	end

	always_comb begin
		rd_addr = seg_q;
		if (state_q == ST_RD && phase_q) rd_addr = seg_q;
		else if (state_q == ST_RD) rd_addr = seg_q + 4'd1;
		else if (state_q == ST_DIRECT) rd_addr = seg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= 6'd0;
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_OUT);
			if (div_run) begin
				cnt_q <= cnt_q - 6'd1;
				num_q <= {num_q[DW-2:0], 1'b0};
				rem_q <= rem_ge ? DW'(rem_shift - {{(DW-33){1'b0}}, den_q})
					: rem_shift[DW-1:0];
				quo_q <= {quo_q[DW-2:0], rem_ge};
			end
			unique case (state_q)
				ST_IDLE: if (start) begin
					status_q <= 1'b0;
					seg_q <= 4'd0;
					phase_q <= 1'b0;
					ch_q <= 2'd0;
					rem_q <= '0;
					quo_q <= '0;
					if (scml_pkg::opcode_t'(cmd.opcode) == scml_pkg::OP_VALUE) begin
						if (max_q > min_q) begin
							num_q <= {off_u[32:0], 16'd0};
							den_q <= {1'b0, range_u};
						end else begin
							num_q <= '0;
							den_q <= 34'd1;
						end
						cnt_q <= 6'(DW);
						state_q <= ST_NORM;
					end else if (scml_pkg::opcode_t'(cmd.opcode) == scml_pkg::OP_STEP) begin
						if ({1'b0, cmd.step_index} >= steps) begin
							status_q <= 1'b1;
							col_acc_q <= '0;
							state_q <= ST_OUT;
						end else if (steps == 11'(points) &&
							cmd.step_index < 10'(scml_pkg::MaxPoints)) begin
							seg_q <= cmd.step_index[3:0];
							state_q <= ST_DIRECT;
						end else begin
							num_q <= {cmd.step_index, 16'd0, 23'd0};
							den_q <= 34'(steps - 11'd1);
							cnt_q <= 6'd26;
							state_q <= ST_SPOS;
						end
					end
				end
				ST_NORM: if (!div_run) begin
					// k = floor(p*(S-1)/65536), then divide k<<16 by S-1
					num_q <= {6'd0, p_times[26:16], 16'd0, 16'd0};
					rem_q <= '0;
					quo_q <= '0;
					den_q <= 34'(steps - 11'd1);
					cnt_q <= 6'd33;
					state_q <= ST_SPOS;
				end
				ST_SPOS: if (!div_run) begin
					q_q <= quo_q[16:0];
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!phase_q) begin
						p1_q <= rd_pos_q;
						c1_q <= rd_col_q;
						if ({1'b0, seg_q} < points - 5'd2 && rd_pos_q < q_q) begin
							seg_q <= seg_q + 4'd1;
							state_q <= ST_RD;
						end else begin
							phase_q <= 1'b1;
							state_q <= ST_RD;
						end
					end else begin
						p0_q <= rd_pos_q;
						c0_q <= rd_col_q;
						state_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					if (p1_q <= p0_q) begin
						col_acc_q <= (q_q >= p1_q) ? c1_q : c0_q;
						state_q <= ST_OUT;
					end else begin
						num_q <= {mix, 22'd0};
						rem_q <= '0;
						quo_q <= '0;
						den_q <= 34'(den_seg);
						cnt_q <= 6'd27;
						state_q <= ST_CH;
					end
				end
				ST_CH: if (!div_run) begin
					col_acc_q[ch_q*8 +: 8] <= quo_q[7:0];
					ch_q <= ch_q + 2'd1;
					if (ch_q == 2'd3) state_q <= ST_OUT;
					else state_q <= ST_SEG;
				end
				ST_DIRECT: state_q <= ST_DIRW;
				ST_DIRW: begin
					col_acc_q <= rd_col_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.color_red = col_acc_q[7:0];
	assign result.color_green = col_acc_q[15:8];
	assign result.color_blue = col_acc_q[23:16];
	assign result.color_alpha = col_acc_q[31:24];
	assign result.status = status_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy after result");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_run |-> (state_q == ST_NORM || state_q == ST_SPOS || state_q == ST_CH))
		else $error("divider running in wrong state");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (col_acc_q == 32'd0))
		else $error("bad step with colour");
`endif

endmodule
